### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the search block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define TLBS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under an active-low reset.
`define TLBS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/tlbs_pkg.sv
// ----------------------------------------------------------------------------
// tlbs_pkg
// Types, codes and helpers shared by the key table search block.
// ----------------------------------------------------------------------------
package tlbs_pkg;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;
	localparam int ACTION_W = 2;
	localparam int SLOT_W = 4;

	localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LINEAR = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_BINARY = 2'd2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic               found;
		logic [COUNT_W-1:0] comparisons;
	} result_t;

	// The count saturates at its largest code.
	function automatic logic [COUNT_W-1:0] cnt_add(input logic [COUNT_W-1:0] c,
		input logic [1:0] inc);
		logic [COUNT_W:0] s;
		s = {1'b0, c} + {{(COUNT_W - 1){1'b0}}, inc};
		return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[COUNT_W-1:0];
	endfunction

endpackage

### rtl/core/tlbs_mem.sv
// ----------------------------------------------------------------------------
// tlbs_mem
// Key table storage: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module tlbs_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [tlbs_pkg::VALUE_W-1:0] wdata,
	input  logic [AW-1:0]               raddr,
	output logic [tlbs_pkg::VALUE_W-1:0] rdata
);
	import tlbs_pkg::*;

	logic [VALUE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/tlbs_ctrl.sv
// ----------------------------------------------------------------------------
// tlbs_ctrl
// Request sequencer: writes loads into the table and walks the probes of a
// linear or binary search, one table read per cycle.
// ----------------------------------------------------------------------------
module tlbs_ctrl #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [tlbs_pkg::ACTION_W-1:0] action,
	input  logic [tlbs_pkg::SLOT_W-1:0]   slot,
	input  logic [tlbs_pkg::VALUE_W-1:0]  value,
	input  logic [tlbs_pkg::COUNT_W-1:0]  entry_count,
	input  logic                          res_free,
	output logic                          res_load,
	output tlbs_pkg::result_t             result,
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_waddr,
	output logic [tlbs_pkg::VALUE_W-1:0]  mem_wdata,
	output logic [AW-1:0]                 mem_raddr,
	input  logic [tlbs_pkg::VALUE_W-1:0]  mem_rdata
);
	import tlbs_pkg::*;

	localparam int IW = AW + 2;

	typedef logic signed [IW-1:0] idx_t;

	state_t state_q, state_d;

	logic                       accept;
	logic                       is_search;
	idx_t                       n_sel;
	idx_t                       first_probe;

	logic signed [VALUE_W-1:0]  key_q;
	idx_t                       n_q;
	idx_t                       probe_q;
	idx_t                       lo_q;
	idx_t                       hi_q;
	logic [COUNT_W-1:0]         cnt_q;
	logic                       binary_q;
	result_t                    res_q;

	logic                       eq;
	logic                       lt;
	logic                       finish;
	idx_t                       next_probe;
	idx_t                       lo_d;
	idx_t                       hi_d;
	logic [COUNT_W-1:0]         cnt_d;
	result_t                    probe_res;

	assign accept = req_valid && !req_stall;
	assign is_search = (action == ACT_LINEAR) || (action == ACT_BINARY);
	assign n_sel = (32'(entry_count) > 32'(DEPTH)) ? IW'(DEPTH) : IW'(entry_count);
	assign first_probe = (action == ACT_BINARY) ? ((n_sel - idx_t'(1)) >>> 1) : '0;

	always_comb begin
		eq = (mem_rdata == key_q);
		lt = ($signed(mem_rdata) < key_q);
		lo_d = lo_q;
		hi_d = hi_q;
		if (!binary_q) begin
			next_probe = probe_q + idx_t'(1);
			finish = eq || (next_probe == n_q);
			cnt_d = cnt_add(cnt_q, 2'd1);
			probe_res.found = eq;
			probe_res.comparisons = cnt_add(cnt_q, 2'd2);
		end else begin
			if (lt) begin
				lo_d = probe_q + idx_t'(1);
			end else begin
				hi_d = probe_q - idx_t'(1);
			end
			next_probe = (lo_d + hi_d) >>> 1;
			finish = eq || (lo_d > hi_d);
			cnt_d = cnt_add(cnt_q, 2'd2);
			probe_res.found = eq;
			probe_res.comparisons = eq ? cnt_add(cnt_q, 2'd2) : cnt_add(cnt_q, 2'd3);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_search) begin
					state_d = (n_sel == '0) ? ST_RESULT : ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (finish) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall = (state_q != ST_IDLE);
		res_load = (state_q == ST_RESULT) && res_free;
		result = res_q;
		mem_we = accept && (action == ACT_LOAD) && (32'(slot) < 32'(DEPTH));
		mem_waddr = AW'(slot);
		mem_wdata = value;
		mem_raddr = (state_q == ST_IDLE) ? first_probe[AW-1:0] : next_probe[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_search) begin
			key_q <= value;
			n_q <= n_sel;
			probe_q <= first_probe;
			lo_q <= '0;
			hi_q <= n_sel - idx_t'(1);
			cnt_q <= '0;
			binary_q <= (action == ACT_BINARY);
			res_q.found <= 1'b0;
			res_q.comparisons <= COUNT_W'(1);
		end else if (state_q == ST_PROBE) begin
			if (finish) begin
				res_q <= probe_res;
			end else begin
				probe_q <= next_probe;
				lo_q <= lo_d;
				hi_q <= hi_d;
				cnt_q <= cnt_d;
			end
		end
	end

endmodule

### rtl/core/table_linear_binary_search.sv
// ----------------------------------------------------------------------------
// table_linear_binary_search
// Key table with linear and binary search and a comparison count.
// ----------------------------------------------------------------------------
// A request carries action, slot and value on req_valid / req_stall. A load
// writes value into the table at slot in the cycle it is accepted and gives
// no result. A search looks for value among the first min(entry_count, DEPTH)
// entries and returns found and comparisons on res_valid / res_stall.
// entry_count is written through cfg_we / cfg_wdata; the user must do so only
// while the block is idle, as the block itself does not enforce it. A search
// is accepted in IDLE, then makes one table probe per cycle in PROBE (up to
// min(entry_count, DEPTH) probes for a linear scan, about log2 of that plus one
// for a binary search) and hands its result to the output register from RESULT.
// Each probe is one table read; the data returns in the cycle after its address.
// The output register frees the request side: loads are taken while a result
// waits, and a search that finishes while a waiting result is stalled holds
// until the result register is taken. Reset clears entry_count and all control
// state; table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module table_linear_binary_search #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [tlbs_pkg::ACTION_W-1:0] action,
	input  logic [tlbs_pkg::SLOT_W-1:0]   slot,
	input  logic [tlbs_pkg::VALUE_W-1:0]  value,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic                          found,
	output logic [tlbs_pkg::COUNT_W-1:0]  comparisons,
	input  logic                          cfg_we,
	input  logic [tlbs_pkg::COUNT_W-1:0]  cfg_wdata
);
	import tlbs_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [COUNT_W-1:0] entry_count_q;
	logic               res_valid_q;
	result_t            res_q;
	logic               res_free;
	logic               res_load;
	result_t            result;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [VALUE_W-1:0] mem_wdata;
	logic [AW-1:0]      mem_raddr;
	logic [VALUE_W-1:0] mem_rdata;

	tlbs_ctrl #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.action     (action),
		.slot       (slot),
		.value      (value),
		.entry_count(entry_count_q),
		.res_free   (res_free),
		.res_load   (res_load),
		.result     (result),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	tlbs_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	assign res_free = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= result;
		end
	end

	assign res_valid = res_valid_q;
	assign found = res_q.found;
	assign comparisons = res_q.comparisons;

	`TLBS_ASSERT_IMP(a_count_nonzero, clk, arst_n, res_valid, comparisons != '0, "result with zero comparisons")
	`TLBS_ASSERT_IMP(a_found_count, clk, arst_n, res_valid && found, comparisons >= 5'd2, "hit with fewer than two comparisons")
	`TLBS_ASSERT_NXT(a_search_busy, clk, arst_n, req_valid && !req_stall && (action == ACT_LINEAR || action == ACT_BINARY), req_stall, "search accepted but block not busy")

endmodule

### tb/sv/table_linear_binary_search_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_linear_binary_search_checker
// Watches the request, answer and register ports of the key table search
// block, keeps its own copy of the table and of entry_count, works out the
// answer of every accepted search and compares it with what the block returns.
// ----------------------------------------------------------------------------
module table_linear_binary_search_checker
	import tlbs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_stall,
	input  logic [ACTION_W-1:0] action,
	input  logic [SLOT_W-1:0]   slot,
	input  logic [VALUE_W-1:0]  value,
	input  logic                res_valid,
	input  logic                res_stall,
	input  logic                found,
	input  logic [COUNT_W-1:0]  comparisons,
	input  logic                cfg_we,
	input  logic [COUNT_W-1:0]  cfg_wdata,
	output int                  mismatches,
	output int                  pending,
	output int                  answers_checked
);

	localparam int TABLE_DEPTH = 16;
	localparam int REPORT_LIMIT = 40;

	logic signed [VALUE_W-1:0] key_table [TABLE_DEPTH];
	logic [COUNT_W-1:0]        entry_count;
	result_t                   expected_answers [$];
	result_t                   want;
	int                        fail_count = 0;
	int                        waiting = 0;
	int                        checked = 0;

	assign mismatches = fail_count;
	assign pending = waiting;
	assign answers_checked = checked;

	task automatic report_mismatch(input string what, input int wanted, input int got);
		if (fail_count < REPORT_LIMIT) begin
			$display("%0t ns: mismatch in %s: expected %0d, got %0d", $time, what, wanted, got);
		end
		fail_count++;
	endtask

	function automatic int active_entries();
		return (int'(entry_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
	endfunction

	function automatic logic [COUNT_W-1:0] count_code(input int count);
		return (count > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(count);
	endfunction

	function automatic result_t linear_scan_result(input logic signed [VALUE_W-1:0] key);
		result_t r;
		int      n;
		int      count;
		n = active_entries();
		count = 0;
		r.found = 1'b0;
		for (int i = 0; i < n; i++) begin
			count++;
			if (key_table[i] == key) begin
				r.found = 1'b1;
				break;
			end
		end
		r.comparisons = count_code(count + 1);
		return r;
	endfunction

	function automatic result_t binary_search_result(input logic signed [VALUE_W-1:0] key);
		result_t r;
		int      lo;
		int      hi;
		int      mid;
		int      count;
		lo = 0;
		hi = active_entries() - 1;
		count = 0;
		r.found = 1'b0;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			count++;
			if (key_table[mid] == key) begin
				r.found = 1'b1;
				break;
			end
			count++;
			if (key_table[mid] < key) begin
				lo = mid + 1;
			end else begin
				hi = mid - 1;
			end
		end
		r.comparisons = count_code(count + 1);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count = '0;
			expected_answers.delete();
			waiting = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_answers.size() == 0) begin
					report_mismatch("answer count, no search waiting", 0, 1);
				end else begin
					want = expected_answers.pop_front();
					checked++;
					if (found !== want.found) begin
						report_mismatch("found", want.found, found);
					end
					if (comparisons !== want.comparisons) begin
						report_mismatch("comparisons", want.comparisons, comparisons);
					end
				end
			end
			if (cfg_we) begin
				entry_count = cfg_wdata;
			end
			if (req_valid && !req_stall) begin
				case (action)
					ACT_LOAD: begin
						key_table[slot] = value;
					end
					ACT_LINEAR: begin
						expected_answers.push_back(linear_scan_result(value));
					end
					ACT_BINARY: begin
						expected_answers.push_back(binary_search_result(value));
					end
					default: begin
					end
				endcase
			end
			waiting = expected_answers.size();
		end
	end

endmodule

### tb/sv/table_linear_binary_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_linear_binary_search_tb
// Drives loads and searches into the key table search block with random gaps
// and output stalls, moves entry_count through its extremes between phases,
// and leaves all answer checking to the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module table_linear_binary_search_tb;

	import tlbs_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam logic signed [VALUE_W-1:0] KEY_MIN = 32'sh80000000;
	localparam logic signed [VALUE_W-1:0] KEY_MAX = 32'sh7FFFFFFF;
	localparam int TARGET_REQUESTS = 650;
	localparam int PHASE_REQUESTS = 30;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int PRESSURE_PHASE = 5;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	logic [ACTION_W-1:0] action;
	logic [SLOT_W-1:0]   slot;
	logic [VALUE_W-1:0]  value;
	logic                res_valid;
	logic                res_stall;
	logic                found;
	logic [COUNT_W-1:0]  comparisons;
	logic                cfg_we;
	logic [COUNT_W-1:0]  cfg_wdata;

	int mismatches;
	int pending;
	int answers_checked;

	bit idle_on = 1'b1;
	int long_holds_wanted = 0;
	int requests_done = 0;
	int loads_sent = 0;
	int linear_sent = 0;
	int binary_sent = 0;
	int unused_sent = 0;
	int settings_used = 0;

	logic signed [VALUE_W-1:0] loaded_keys [16];

	table_linear_binary_search #(
		.DEPTH(16)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.action     (action),
		.slot       (slot),
		.value      (value),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.found      (found),
		.comparisons(comparisons),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	table_linear_binary_search_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("Run did not finish in time, %0d answers still outstanding.", pending);
		$display("*** FAILED ***");
		$finish;
	end

	// The output side stalls in short random bursts and, when asked, holds off for
	// one long stretch so that the block backs up into its request port.
	initial begin
		int holds_done;
		holds_done = 0;
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done < long_holds_wanted) begin
				holds_done++;
				res_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				res_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	task automatic send_request(input logic [ACTION_W-1:0] act, input logic [SLOT_W-1:0] pos,
		input logic [VALUE_W-1:0] val);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		action <= act;
		slot <= pos;
		value <= val;
		do @(posedge clk); while (req_stall);
		case (act)
			ACT_LOAD: begin
				loaded_keys[pos] = val;
				loads_sent++;
				requests_done++;
			end
			ACT_LINEAR: begin
				linear_sent++;
				requests_done++;
			end
			ACT_BINARY: begin
				binary_sent++;
				requests_done++;
			end
			default: begin
				unused_sent++;
			end
		endcase
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_entry_count(input logic [COUNT_W-1:0] count);
		cfg_we <= 1'b1;
		cfg_wdata <= count;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		int                        phase;
		int                        roll;
		int                        idx;
		int                        tmp;
		int                        j;
		int                        keys [16];
		bit                        sorted;
		bit                        narrow;
		bit                        descending;
		logic [COUNT_W-1:0]        count;
		logic [ACTION_W-1:0]       act;
		logic signed [VALUE_W-1:0] key;

		arst_n = 1'b0;
		req_valid = 1'b0;
		action = ACT_LOAD;
		slot = '0;
		value = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Searches on the empty table after reset, and a request with the unused
		// action code.
		send_request(ACT_LINEAR, 4'd9, 32'd0);
		send_request(ACT_BINARY, 4'd6, 32'hFFFFFFFF);
		send_request(ACT_UNUSED, 4'd15, 32'h5A5A5A5A);

		for (int i = 0; i < 16; i++) begin
			if (i == 0) begin
				key = KEY_MIN;
			end else if (i == 15) begin
				key = KEY_MAX;
			end else begin
				key = (i - 7) * 1000;
			end
			send_request(ACT_LOAD, SLOT_W'(i), key);
		end
		wait_idle();
		write_entry_count(5'd16);
		send_request(ACT_LINEAR, 4'd0, KEY_MIN);
		send_request(ACT_LINEAR, 4'd15, KEY_MAX);
		send_request(ACT_BINARY, 4'd3, KEY_MAX);
		send_request(ACT_BINARY, 4'd12, KEY_MIN);
		send_request(ACT_LINEAR, 4'd5, 32'd123);
		send_request(ACT_BINARY, 4'd10, 32'd123);

		phase = 0;
		while (requests_done < TARGET_REQUESTS) begin
			wait_idle();
			case (phase)
				0: count = 5'd31;
				1: count = 5'd0;
				2: count = 5'd1;
				3: count = 5'd15;
				4: count = 5'd17;
				5: count = 5'd16;
				default: count = COUNT_W'($urandom_range(0, 31));
			endcase
			write_entry_count(count);

			// Most tables are loaded in ascending order so that binary searches
			// follow their intended path; some are left unsorted.
			sorted = ($urandom_range(0, 4) != 0);
			narrow = ($urandom_range(0, 2) == 0);
			descending = $urandom_range(0, 1);
			for (int i = 0; i < 16; i++) begin
				keys[i] = narrow ? ($urandom_range(0, 40) - 20) : int'($urandom);
			end
			if (sorted) begin
				for (int i = 1; i < 16; i++) begin
					tmp = keys[i];
					j = i - 1;
					while (j >= 0 && keys[j] > tmp) begin
						keys[j + 1] = keys[j];
						j--;
					end
					keys[j + 1] = tmp;
				end
			end
			for (int k = 0; k < 16; k++) begin
				idx = descending ? 15 - k : k;
				send_request(ACT_LOAD, SLOT_W'(idx), keys[idx]);
			end

			if (phase == PRESSURE_PHASE) begin
				long_holds_wanted++;
			end

			repeat (PHASE_REQUESTS) begin
				roll = $urandom_range(0, 99);
				if (roll < 6) begin
					send_request(ACT_UNUSED, SLOT_W'($urandom_range(0, 15)), $urandom);
				end else if (roll < 13) begin
					send_request(ACT_LOAD, SLOT_W'($urandom_range(0, 15)), $urandom);
				end else begin
					act = $urandom_range(0, 1) ? ACT_LINEAR : ACT_BINARY;
					idx = $urandom_range(0, 15);
					roll = $urandom_range(0, 9);
					if (roll < 5) begin
						key = loaded_keys[idx];
					end else if (roll < 7) begin
						key = $urandom_range(0, 1) ? loaded_keys[idx] + 1 : loaded_keys[idx] - 1;
					end else if (roll == 7) begin
						key = $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
					end else begin
						key = $urandom;
					end
					send_request(act, SLOT_W'($urandom_range(0, 15)), key);
				end
				if (requests_done > TARGET_REQUESTS - 90) begin
					idle_on = 1'b0;
				end
			end
			phase++;
		end

		wait_idle();
		$display("Sent %0d loads, %0d linear and %0d binary searches, %0d unused-action requests.",
			loads_sent, linear_sent, binary_sent, unused_sent);
		$display("Checked %0d answers across %0d entry_count settings, with one long output hold.",
			answers_checked, settings_used);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
